/* rtl/core/ebcpu_pkg.sv */
// shared types, codes and reset values for the 8-bit cpu alu and load executor
package ebcpu_pkg;

  localparam logic [7:0] OP_HALT   = 8'h76;
  localparam logic [7:0] OP_PREFIX = 8'hCB;

  // upper five bits of a prefixed swap opcode
  localparam logic [4:0] CB_SWAP_HI = 5'b00110;

  // two-bit opcode groups
  localparam logic [1:0] GRP_LOAD = 2'b01;
  localparam logic [1:0] GRP_ALU  = 2'b10;

  localparam logic [4:0] CYC_BASE = 5'd4;
  localparam logic [4:0] CYC_MEM  = 5'd4;
  localparam logic [4:0] CYC_CB   = 5'd4;
  localparam logic [4:0] CYC_MAX  = 5'd16;

  typedef enum logic [2:0] {
    R_B  = 3'd0,
    R_C  = 3'd1,
    R_D  = 3'd2,
    R_E  = 3'd3,
    R_H  = 3'd4,
    R_L  = 3'd5,
    R_HL = 3'd6,
    R_A  = 3'd7
  } reg_code_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_ADC = 3'd1,
    ALU_SUB = 3'd2,
    ALU_SBC = 3'd3,
    ALU_AND = 3'd4,
    ALU_XOR = 3'd5,
    ALU_OR  = 3'd6,
    ALU_CP  = 3'd7
  } alu_op_t;

  // flag nibble bit positions: z n h c
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  localparam logic [7:0]  RST_A  = 8'h01;
  localparam logic [3:0]  RST_F  = 4'h0;
  localparam logic [7:0]  RST_B  = 8'hFF;
  localparam logic [7:0]  RST_C  = 8'h13;
  localparam logic [7:0]  RST_D  = 8'h00;
  localparam logic [7:0]  RST_E  = 8'hC1;
  localparam logic [7:0]  RST_H  = 8'h84;
  localparam logic [7:0]  RST_L  = 8'h93;
  localparam logic [15:0] RST_PC = 16'h0100;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] prefix_byte;
    logic [7:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_a;
    logic [7:0]  out_flags;
    logic [15:0] out_bc;
    logic [15:0] out_de;
    logic [15:0] out_hl;
    logic [15:0] out_pc;
    logic        mem_write;
    logic [7:0]  write_data;
    logic [4:0]  cycle_count;
    logic        handled;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  acc;
    logic [3:0]  flag_bits;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [15:0] prog_counter;
  } arch_t;

  localparam arch_t ARCH_RESET = '{
    acc:          RST_A,
    flag_bits:    RST_F,
    reg_b:        RST_B,
    reg_c:        RST_C,
    reg_d:        RST_D,
    reg_e:        RST_E,
    reg_h:        RST_H,
    reg_l:        RST_L,
    prog_counter: RST_PC
  };

  function automatic logic [7:0] read_reg(arch_t st, reg_code_t idx, logic [7:0] mem);
    logic [7:0] v;
    unique case (idx)
      R_B:     v = st.reg_b;
      R_C:     v = st.reg_c;
      R_D:     v = st.reg_d;
      R_E:     v = st.reg_e;
      R_H:     v = st.reg_h;
      R_L:     v = st.reg_l;
      R_HL:    v = mem;
      default: v = st.acc;
    endcase
    return v;
  endfunction

  function automatic arch_t write_reg(arch_t st, reg_code_t idx, logic [7:0] v);
    arch_t r;
    r = st;
    unique case (idx)
      R_B:     r.reg_b = v;
      R_C:     r.reg_c = v;
      R_D:     r.reg_d = v;
      R_E:     r.reg_e = v;
      R_H:     r.reg_h = v;
      R_L:     r.reg_l = v;
      R_HL:    r = st;
      default: r.acc = v;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ebcpu_exec.sv */
// instruction decode, alu and register writeback for one transaction
module ebcpu_exec (
  input  ebcpu_pkg::arch_t    cur,
  input  ebcpu_pkg::in_item_t item,
  output ebcpu_pkg::arch_t    nxt,
  output ebcpu_pkg::out_item_t res
);
  import ebcpu_pkg::*;

  reg_code_t  ld_dst;
  reg_code_t  src;
  reg_code_t  sw_tgt;
  alu_op_t    kind;
  logic [7:0] v;
  logic [7:0] sw_v;
  logic [7:0] sw_r;
  logic [7:0] alu_r;
  logic [3:0] alu_f;
  logic       cin;
  logic [8:0] wide;
  logic [4:0] half;
  logic       mw;
  logic [7:0] wd;
  logic [4:0] cycles;
  logic       handled;

  assign ld_dst = reg_code_t'(item.opcode[5:3]);
  assign src    = reg_code_t'(item.opcode[2:0]);
  assign kind   = alu_op_t'(item.opcode[5:3]);
  assign sw_tgt = reg_code_t'(item.prefix_byte[2:0]);
  assign v      = read_reg(cur, src, item.mem_data);
  assign sw_v   = read_reg(cur, sw_tgt, item.mem_data);
  assign sw_r   = {sw_v[3:0], sw_v[7:4]};

  // carry in only for adc and sbc
  assign cin = ((kind == ALU_ADC) || (kind == ALU_SBC)) ? cur.flag_bits[FLAG_C] : 1'b0;

  always_comb begin
    alu_f = '0;
    wide  = '0;
    half  = '0;
    case (kind)
      ALU_ADD, ALU_ADC: begin
        wide = {1'b0, cur.acc} + {1'b0, v} + {8'd0, cin};
        half = {1'b0, cur.acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
        alu_r = wide[7:0];
        alu_f[FLAG_H] = half[4];
        alu_f[FLAG_C] = wide[8];
      end
      ALU_SUB, ALU_SBC, ALU_CP: begin
        wide = {1'b0, cur.acc} - {1'b0, v} - {8'd0, cin};
        half = {1'b0, cur.acc[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
        alu_r = wide[7:0];
        alu_f[FLAG_N] = 1'b1;
        alu_f[FLAG_H] = half[4];
        alu_f[FLAG_C] = wide[8];
      end
      ALU_AND: begin
        alu_r = cur.acc & v;
        alu_f[FLAG_H] = 1'b1;
      end
      ALU_XOR: alu_r = cur.acc ^ v;
      default: alu_r = cur.acc | v;
    endcase
    alu_f[FLAG_Z] = (alu_r == 8'd0);
  end

  always_comb begin
    nxt     = cur;
    nxt.prog_counter = cur.prog_counter + 16'd1;
    mw      = 1'b0;
    wd      = '0;
    cycles  = CYC_BASE;
    handled = 1'b0;
    if ((item.opcode[7:6] == GRP_LOAD) && (item.opcode != OP_HALT)) begin
      handled = 1'b1;
      if (src == R_HL) cycles = cycles + CYC_MEM;
      if (ld_dst == R_HL) begin
        mw     = 1'b1;
        wd     = v;
        cycles = cycles + CYC_MEM;
      end else begin
        nxt = write_reg(nxt, ld_dst, v);
      end
    end else if (item.opcode[7:6] == GRP_ALU) begin
      handled = 1'b1;
      if (src == R_HL) cycles = cycles + CYC_MEM;
      if (kind != ALU_CP) nxt.acc = alu_r;
      nxt.flag_bits = alu_f;
    end else if (item.opcode == OP_PREFIX) begin
      nxt.prog_counter = cur.prog_counter + 16'd2;
      cycles = cycles + CYC_CB;
      if (item.prefix_byte[7:3] == CB_SWAP_HI) begin
        handled = 1'b1;
        if (sw_tgt == R_HL) begin
          mw     = 1'b1;
          wd     = sw_r;
          cycles = cycles + CYC_MEM + CYC_MEM;
        end else begin
          nxt = write_reg(nxt, sw_tgt, sw_r);
        end
        nxt.flag_bits = {(sw_r == 8'd0), 3'b000};
      end
    end
  end

  always_comb begin
    res.out_a       = nxt.acc;
    res.out_flags   = {nxt.flag_bits, 4'b0000};
    res.out_bc      = {nxt.reg_b, nxt.reg_c};
    res.out_de      = {nxt.reg_d, nxt.reg_e};
    res.out_hl      = {nxt.reg_h, nxt.reg_l};
    res.out_pc      = nxt.prog_counter;
    res.mem_write   = mw;
    res.write_data  = wd;
    res.cycle_count = cycles;
    res.handled     = handled;
  end

endmodule

/* rtl/core/eight_bit_cpu_alu_load_execute_top.sv */
// top level of the 8-bit cpu alu and load executor
//
//   channel | direction | handshake          | payload
//   in      | into      | in_valid/in_stall   | ebcpu_pkg::in_item_t
//   out     | out of    | out_valid/out_stall | ebcpu_pkg::out_item_t
//
// one transaction per cycle while out_stall does not hold the output; an item is
// accepted into the input register, then passes through decode and the 8-bit
// adder into the result register
// the register file updates when the input register hands its item on
// rst is synchronous and restores the power-on register values
// out_stall holds the result register while it is valid; in_stall rises only while the input
// register holds an item that cannot move on
module eight_bit_cpu_alu_load_execute_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ebcpu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ebcpu_pkg::out_item_t out_data
);
  import ebcpu_pkg::*;

  logic      s1_valid;
  in_item_t  s1_item;
  arch_t     state;
  arch_t     state_next;
  out_item_t res;
  logic      adv;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = s1_valid && !adv;

  ebcpu_exec u_exec (
    .cur  (state),
    .item (s1_item),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= ARCH_RESET;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (adv) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          state <= state_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item <= in_data;
    end
    if (adv && s1_valid) begin
      out_data <= res;
    end
  end

`ifndef NO_ASSERTIONS
  a_pc_step: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv) |=>
      (state.prog_counter == $past(state.prog_counter) + 16'd1) ||
      (state.prog_counter == $past(state.prog_counter) + 16'd2))
    else $error("pc moved by other than one or two");

  a_no_store_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.mem_write) |-> (out_data.write_data == 8'd0))
    else $error("write data nonzero without a store");

  a_cycles_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.cycle_count >= CYC_BASE) && (out_data.cycle_count <= CYC_MAX))
    else $error("cycle count out of range");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without a blocked item");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(s1_valid && adv) |=> $stable(state))
    else $error("register file changed without a transaction");
`endif

endmodule

/* tb/tb_eight_bit_cpu_alu_load_execute_top.sv */
// testbench for the 8-bit cpu alu and load executor, checked against a register-level predictor
`timescale 1ns / 1ps

module tb_eight_bit_cpu_alu_load_execute_top;
  import ebcpu_pkg::*;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 60;

  typedef struct packed {
    logic [7:0]  a;
    logic [3:0]  f;
    logic [7:0]  b;
    logic [7:0]  c;
    logic [7:0]  d;
    logic [7:0]  e;
    logic [7:0]  h;
    logic [7:0]  l;
    logic [15:0] sp;
    logic [15:0] pc;
  } cpu_regs_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  cpu_regs_t arch_now;
  out_item_t pending_results[$];
  dir_row_t  dir_rows[$];
  bit        calm = 1'b0;
  int        error_count = 0;
  int        cycle_cnt = 0;

  eight_bit_cpu_alu_load_execute_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[eight_bit_cpu_alu_load_execute_top] ERROR");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (error_count < PRINT_LIMIT) $display("%0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic logic [7:0] operand_of(reg_code_t r, logic [7:0] mem);
    case (r)
      R_B:     return arch_now.b;
      R_C:     return arch_now.c;
      R_D:     return arch_now.d;
      R_E:     return arch_now.e;
      R_H:     return arch_now.h;
      R_L:     return arch_now.l;
      R_HL:    return mem;
      default: return arch_now.a;
    endcase
  endfunction

  function automatic void store_reg(reg_code_t r, logic [7:0] v);
    case (r)
      R_B:     arch_now.b = v;
      R_C:     arch_now.c = v;
      R_D:     arch_now.d = v;
      R_E:     arch_now.e = v;
      R_H:     arch_now.h = v;
      R_L:     arch_now.l = v;
      R_HL:    ;
      default: arch_now.a = v;
    endcase
  endfunction

  function automatic out_item_t execute_instr(in_item_t item);
    out_item_t res;
    reg_code_t src;
    reg_code_t dst;
    alu_op_t   kind;
    logic [7:0] v;
    logic [7:0] r;
    logic [8:0] full;
    logic [4:0] half;
    logic       cin;
    logic       hf;
    logic       cf;
    logic       nf;
    res = '0;
    res.cycle_count = CYC_BASE;
    arch_now.pc = arch_now.pc + 16'd1;
    src = reg_code_t'(item.opcode[2:0]);
    dst = reg_code_t'(item.opcode[5:3]);
    kind = alu_op_t'(item.opcode[5:3]);
    if (item.opcode[7:6] == GRP_LOAD && item.opcode != OP_HALT) begin
      v = operand_of(src, item.mem_data);
      if (src == R_HL) res.cycle_count += CYC_MEM;
      if (dst == R_HL) begin
        res.mem_write = 1'b1;
        res.write_data = v;
        res.cycle_count += CYC_MEM;
      end else begin
        store_reg(dst, v);
      end
      res.handled = 1'b1;
    end else if (item.opcode[7:6] == GRP_ALU) begin
      v = operand_of(src, item.mem_data);
      if (src == R_HL) res.cycle_count += CYC_MEM;
      cin = arch_now.f[FLAG_C];
      hf = 1'b0;
      cf = 1'b0;
      nf = 1'b0;
      case (kind)
        ALU_ADD, ALU_ADC: begin
          if (kind == ALU_ADD) cin = 1'b0;
          full = {1'b0, arch_now.a} + {1'b0, v} + {8'd0, cin};
          half = {1'b0, arch_now.a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
          hf = half[4];
          cf = full[8];
          r = full[7:0];
        end
        ALU_SUB, ALU_SBC, ALU_CP: begin
          if (kind != ALU_SBC) cin = 1'b0;
          full = {1'b0, arch_now.a} - {1'b0, v} - {8'd0, cin};
          half = {1'b0, arch_now.a[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
          hf = half[4];
          cf = full[8];
          nf = 1'b1;
          r = full[7:0];
        end
        ALU_AND: begin
          r = arch_now.a & v;
          hf = 1'b1;
        end
        ALU_XOR: r = arch_now.a ^ v;
        default: r = arch_now.a | v;
      endcase
      if (kind != ALU_CP) arch_now.a = r;
      arch_now.f = {r == 8'h00, nf, hf, cf};
      res.handled = 1'b1;
    end else if (item.opcode == OP_PREFIX) begin
      arch_now.pc = arch_now.pc + 16'd1;
      res.cycle_count += CYC_CB;
      if (item.prefix_byte[7:3] == CB_SWAP_HI) begin
        src = reg_code_t'(item.prefix_byte[2:0]);
        v = operand_of(src, item.mem_data);
        r = {v[3:0], v[7:4]};
        if (src == R_HL) begin
          res.mem_write = 1'b1;
          res.write_data = r;
          res.cycle_count += CYC_MEM + CYC_MEM;
        end else begin
          store_reg(src, r);
        end
        arch_now.f = {r == 8'h00, 3'b000};
        res.handled = 1'b1;
      end
    end
    res.out_a = arch_now.a;
    res.out_flags = {arch_now.f, 4'h0};
    res.out_bc = {arch_now.b, arch_now.c};
    res.out_de = {arch_now.d, arch_now.e};
    res.out_hl = {arch_now.h, arch_now.l};
    res.out_pc = arch_now.pc;
    return res;
  endfunction

  function automatic out_item_t untouched_result(logic [15:0] pc, logic [4:0] cyc);
    out_item_t res;
    res = '0;
    res.out_a = RST_A;
    res.out_flags = {RST_F, 4'h0};
    res.out_bc = {RST_B, RST_C};
    res.out_de = {RST_D, RST_E};
    res.out_hl = {RST_H, RST_L};
    res.out_pc = pc;
    res.cycle_count = cyc;
    return res;
  endfunction

  function automatic void add_row(logic [7:0] op, logic [7:0] pb, logic [7:0] mem);
    dir_row_t row;
    row.item = '{opcode: op, prefix_byte: pb, mem_data: mem};
    row.typed = 1'b0;
    row.want = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_typed_row(logic [7:0] op, logic [7:0] pb, logic [7:0] mem,
                                        out_item_t want);
    dir_row_t row;
    row.item = '{opcode: op, prefix_byte: pb, mem_data: mem};
    row.typed = 1'b1;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.prefix_byte = 8'($urandom);
    if ($urandom_range(9) == 0) it.mem_data = $urandom_range(1) ? 8'hFF : 8'h00;
    else it.mem_data = 8'($urandom);
    if (sel < 40) begin
      it.opcode = {GRP_LOAD, 6'($urandom)};
    end else if (sel < 80) begin
      it.opcode = {GRP_ALU, 6'($urandom)};
    end else if (sel < 92) begin
      it.opcode = OP_PREFIX;
      if ($urandom_range(3) != 0) it.prefix_byte = {CB_SWAP_HI, 3'($urandom)};
    end else begin
      it.opcode = 8'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t item, input bit typed, input out_item_t want);
    out_item_t predicted;
    while (!calm && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = execute_instr(item);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 35);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result with no pending transaction: %h", out_data));
      end else begin
        want = pending_results.pop_front();
        check_field("out_a", 16'(out_data.out_a), 16'(want.out_a));
        check_field("out_flags", 16'(out_data.out_flags), 16'(want.out_flags));
        check_field("out_bc", out_data.out_bc, want.out_bc);
        check_field("out_de", out_data.out_de, want.out_de);
        check_field("out_hl", out_data.out_hl, want.out_hl);
        check_field("out_pc", out_data.out_pc, want.out_pc);
        check_field("mem_write", 16'(out_data.mem_write), 16'(want.mem_write));
        check_field("write_data", 16'(out_data.write_data), 16'(want.write_data));
        check_field("cycle_count", 16'(out_data.cycle_count), 16'(want.cycle_count));
        check_field("handled", 16'(out_data.handled), 16'(want.handled));
      end
    end
  end

  initial begin
    out_item_t no_want;
    no_want = '0;
    arch_now = '{a: RST_A, f: RST_F, b: RST_B, c: RST_C, d: RST_D, e: RST_E,
                 h: RST_H, l: RST_L, sp: 16'hFFFE, pc: RST_PC};

    // skipped opcodes right after reset leave every register but the pc alone
    add_typed_row(OP_HALT, 8'h00, 8'hFF, untouched_result(16'h0101, 5'd4));
    add_typed_row(OP_PREFIX, 8'h38, 8'h00, untouched_result(16'h0103, 5'd8));
    add_typed_row(8'h00, 8'hFF, 8'h00, untouched_result(16'h0104, 5'd4));
    add_typed_row(8'hFF, 8'h00, 8'hFF, untouched_result(16'h0105, 5'd4));
    add_typed_row(OP_PREFIX, 8'h2F, 8'hFF, untouched_result(16'h0107, 5'd8));
    add_row(8'h7E, 8'h00, 8'hFF);
    add_row(8'h86, 8'h00, 8'h01);
    add_row(8'h8E, 8'h00, 8'hFF);
    add_row(8'h98, 8'hFF, 8'h00);
    add_row(8'h97, 8'h00, 8'h00);
    add_row(8'hA6, 8'h00, 8'h00);
    add_row(8'hAE, 8'h00, 8'hFF);
    add_row(8'hB0, 8'h00, 8'h00);
    add_row(8'hBE, 8'h00, 8'h80);
    add_row(8'h77, 8'h00, 8'h00);
    add_row(8'h66, 8'h00, 8'h00);
    add_row(8'h6E, 8'h00, 8'hFF);
    add_row(8'h43, 8'h00, 8'h00);
    add_row(OP_PREFIX, 8'h30, 8'h00);
    add_row(OP_PREFIX, 8'h36, 8'hA5);
    add_row(OP_PREFIX, 8'h36, 8'h00);
    add_row(OP_PREFIX, 8'h37, 8'h00);
    add_row(8'h57, 8'h00, 8'h00);
    add_row(8'h4D, 8'h00, 8'h00);
    add_row(8'h9E, 8'h00, 8'hFF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 500 && n < 800);
      send_item(random_item(), 1'b0, no_want);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("[eight_bit_cpu_alu_load_execute_top] OK");
    end else begin
      $display("[eight_bit_cpu_alu_load_execute_top] ERROR");
    end
    $finish;
  end

endmodule
